FILE: src/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types, constants and codes of the triangle face normal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam logic [31:0] ScaleReset  = 32'h0001_0000;

  // last step of each multi-cycle phase
  localparam logic [5:0] LoadLast   = 6'd3;
  localparam logic [5:0] ReadLast   = 6'd3;
  localparam logic [5:0] CrossLast  = 6'd6;
  localparam logic [5:0] SquareLast = 6'd3;
  localparam logic [5:0] SqrtLast   = 6'd31;
  localparam logic [5:0] DivLast    = 6'd17;
  localparam logic [1:0] CompLast   = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic        [15:0] corner_a;
    logic        [15:0] corner_b;
    logic        [15:0] corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               index_error;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_READ,
    ST_EDGE,
    ST_CROSS,
    ST_MAG,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_CHECK,
    OP_READ,
    OP_EDGE,
    OP_CROSS,
    OP_MAG,
    OP_NORM,
    OP_SQUARE,
    OP_SQRT,
    OP_DIV,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] step;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic in_func;
    logic full;
    logic idx_err;
    logic zero;
    logic norm_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: src/tfn_ctrl.sv
// ----------------------------------------------------------------------------
// tfn_ctrl
// Sequencer: walks one item through load or normal phases, counts steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfn_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  tfn_pkg::status_t   status_i,
  output tfn_pkg::cmd_t      cmd_o
);

  tfn_pkg::state_e state_q, state_d;
  logic [5:0]      step_q, step_d;
  logic [1:0]      comp_q, comp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfn_pkg::ST_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tfn_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_func)   state_d = tfn_pkg::ST_CHECK;
          else if (!status_i.full) state_d = tfn_pkg::ST_LOAD;
        end
      end
      tfn_pkg::ST_LOAD: begin
        if (step_q == tfn_pkg::LoadLast) state_d = tfn_pkg::ST_IDLE;
      end
      tfn_pkg::ST_CHECK: begin
        state_d = status_i.idx_err ? tfn_pkg::ST_OUT : tfn_pkg::ST_READ;
      end
      tfn_pkg::ST_READ: begin
        if (step_q == tfn_pkg::ReadLast) state_d = tfn_pkg::ST_EDGE;
      end
      tfn_pkg::ST_EDGE:  state_d = tfn_pkg::ST_CROSS;
      tfn_pkg::ST_CROSS: begin
        if (step_q == tfn_pkg::CrossLast) state_d = tfn_pkg::ST_MAG;
      end
      tfn_pkg::ST_MAG:   state_d = tfn_pkg::ST_NORM;
      tfn_pkg::ST_NORM: begin
        priority if (status_i.zero)  state_d = tfn_pkg::ST_OUT;
        else if (status_i.norm_done) state_d = tfn_pkg::ST_SQUARE;
      end
      tfn_pkg::ST_SQUARE: begin
        if (step_q == tfn_pkg::SquareLast) state_d = tfn_pkg::ST_SQRT;
      end
      tfn_pkg::ST_SQRT: begin
        if (step_q == tfn_pkg::SqrtLast) state_d = tfn_pkg::ST_DIV;
      end
      tfn_pkg::ST_DIV: begin
        if (step_q == tfn_pkg::DivLast && comp_q == tfn_pkg::CompLast) begin
          state_d = tfn_pkg::ST_OUT;
        end
      end
      tfn_pkg::ST_OUT: begin
        if (status_i.out_free) state_d = tfn_pkg::ST_IDLE;
      end
      default: state_d = tfn_pkg::ST_IDLE;
    endcase
  end

  // outputs and step counters
  always_comb begin
    in_ready_o  = (state_q == tfn_pkg::ST_IDLE);
    cmd_o.step  = step_q;
    cmd_o.comp  = comp_q;
    unique case (state_q)
      tfn_pkg::ST_IDLE:   cmd_o.op = in_valid_i ? tfn_pkg::OP_CAPTURE : tfn_pkg::OP_NONE;
      tfn_pkg::ST_LOAD:   cmd_o.op = tfn_pkg::OP_LOAD;
      tfn_pkg::ST_CHECK:  cmd_o.op = tfn_pkg::OP_CHECK;
      tfn_pkg::ST_READ:   cmd_o.op = tfn_pkg::OP_READ;
      tfn_pkg::ST_EDGE:   cmd_o.op = tfn_pkg::OP_EDGE;
      tfn_pkg::ST_CROSS:  cmd_o.op = tfn_pkg::OP_CROSS;
      tfn_pkg::ST_MAG:    cmd_o.op = tfn_pkg::OP_MAG;
      tfn_pkg::ST_NORM:   cmd_o.op = tfn_pkg::OP_NORM;
      tfn_pkg::ST_SQUARE: cmd_o.op = tfn_pkg::OP_SQUARE;
      tfn_pkg::ST_SQRT:   cmd_o.op = tfn_pkg::OP_SQRT;
      tfn_pkg::ST_DIV:    cmd_o.op = tfn_pkg::OP_DIV;
      tfn_pkg::ST_OUT:    cmd_o.op = tfn_pkg::OP_OUT;
      default:            cmd_o.op = tfn_pkg::OP_NONE;
    endcase

    step_d = step_q + 6'd1;
    comp_d = comp_q;
    priority if (state_d != state_q) begin
      step_d = '0;
      comp_d = '0;
    end else if (state_q == tfn_pkg::ST_DIV && step_q == tfn_pkg::DivLast) begin
      // next component of the divide
      step_d = '0;
      comp_d = comp_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: src/tfn_dp.sv
// ----------------------------------------------------------------------------
// tfn_dp
// Datapath: vertex store, shared multiplier, normalizer, square root,
// divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfn_dp #(
  parameter int unsigned MaxVertices = tfn_pkg::MaxVertices
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [31:0]         cfg_wdata_i,
  input  tfn_pkg::in_item_t   in_item_i,
  input  tfn_pkg::cmd_t       cmd_i,
  output tfn_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tfn_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam int unsigned IW = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0] CountMax = CW'(MaxVertices);

  // control state
  logic [31:0]   scale_q;
  logic [CW-1:0] count_q;
  logic          out_valid_q;

  // payload
  tfn_pkg::in_item_t  in_q;
  tfn_pkg::out_item_t out_item_q;
  logic               err_q;
  logic signed [67:0] prod_q;
  logic               ld_neg_q;
  logic signed [31:0] mem_x [MaxVertices];
  logic signed [31:0] mem_y [MaxVertices];
  logic signed [31:0] mem_z [MaxVertices];
  logic signed [31:0] rd_x_q, rd_y_q, rd_z_q;
  logic signed [31:0] v_q   [3][3];   // [corner][axis]
  logic signed [32:0] e0_q  [3];
  logic signed [32:0] e1_q  [3];
  logic signed [66:0] w_q   [3];
  logic        [66:0] mag_q [3];
  logic               neg_q [3];
  logic        [63:0] sum_q, root_q, bit_q;
  logic        [31:0] rem_q;
  logic        [15:0] low_q, quot_q;
  logic signed [15:0] n_q   [3];

  // combinational
  logic signed [31:0] ld_coord;
  logic        [31:0] ld_mag;
  logic        [63:0] ld_rnd;
  logic        [47:0] ld_q48;
  logic        [31:0] ld_val;
  logic [1:0]         ld_wsel;
  logic [5:0]         step_m1;
  logic signed [33:0] mul_a, mul_b;
  logic [15:0]        rd_corner;
  logic [AW-1:0]      waddr, raddr;
  logic [66:0]        or_all;
  logic [63:0]        sq_trial;
  logic [46:0]        div_num;
  logic [32:0]        div_rem2, div_dsr;
  logic [15:0]        div_sat;
  logic               idx_err;
  logic               out_free;

  assign step_m1  = cmd_i.step - 6'd1;
  assign ld_wsel  = step_m1[1:0];
  assign waddr    = count_q[AW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  assign idx_err = (IW'(in_q.corner_a) >= IW'(count_q)) ||
                   (IW'(in_q.corner_b) >= IW'(count_q)) ||
                   (IW'(in_q.corner_c) >= IW'(count_q));

  assign or_all = mag_q[0] | mag_q[1] | mag_q[2];

  always_comb begin
    status_o.in_func   = in_item_i.func;
    status_o.full      = (count_q == CountMax);
    status_o.idx_err   = idx_err;
    status_o.zero      = (or_all == '0);
    status_o.norm_done = (or_all[66:31] == '0) && or_all[30];
    status_o.out_free  = out_free;
  end

  // vertex scaling: magnitude times scale, round at bit 16, saturate
  always_comb begin
    unique case (cmd_i.step[1:0])
      2'd0:    ld_coord = in_q.coord_x;
      2'd1:    ld_coord = in_q.coord_y;
      default: ld_coord = in_q.coord_z;
    endcase
    ld_mag = ld_coord[31] ? (32'd0 - ld_coord) : ld_coord;
    ld_rnd = prod_q[63:0] + 64'h8000;
    ld_q48 = ld_rnd[63:16];
    if (ld_neg_q) begin
      ld_val = (ld_q48 > 48'h8000_0000) ? 32'h8000_0000 : (32'd0 - ld_q48[31:0]);
    end else begin
      ld_val = (ld_q48 > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : ld_q48[31:0];
    end
  end

  // read address: one corner per step
  always_comb begin
    unique case (cmd_i.step[1:0])
      2'd0:    rd_corner = in_q.corner_a;
      2'd1:    rd_corner = in_q.corner_b;
      default: rd_corner = in_q.corner_c;
    endcase
    raddr = rd_corner[AW-1:0];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      tfn_pkg::OP_LOAD: begin
        mul_a = {2'b00, ld_mag};
        mul_b = {2'b00, scale_q};
      end
      tfn_pkg::OP_CROSS: begin
        case (cmd_i.step[2:0])
          3'd0: begin mul_a = {e0_q[1][32], e0_q[1]}; mul_b = {e1_q[2][32], e1_q[2]}; end
          3'd1: begin mul_a = {e0_q[2][32], e0_q[2]}; mul_b = {e1_q[1][32], e1_q[1]}; end
          3'd2: begin mul_a = {e0_q[2][32], e0_q[2]}; mul_b = {e1_q[0][32], e1_q[0]}; end
          3'd3: begin mul_a = {e0_q[0][32], e0_q[0]}; mul_b = {e1_q[2][32], e1_q[2]}; end
          3'd4: begin mul_a = {e0_q[0][32], e0_q[0]}; mul_b = {e1_q[1][32], e1_q[1]}; end
          default: begin
            mul_a = {e0_q[1][32], e0_q[1]};
            mul_b = {e1_q[0][32], e1_q[0]};
          end
        endcase
      end
      tfn_pkg::OP_SQUARE: begin
        mul_a = {3'b000, mag_q[cmd_i.step[1:0]][30:0]};
        mul_b = {3'b000, mag_q[cmd_i.step[1:0]][30:0]};
      end
      default: ;
    endcase
  end

  // square root trial and divider step
  always_comb begin
    sq_trial = root_q + bit_q;
    div_num  = {1'b0, mag_q[cmd_i.comp][30:0], 15'd0} + {16'd0, root_q[31:1]};
    div_rem2 = {rem_q, low_q[15]};
    div_dsr  = {1'b0, root_q[31:0]};
    div_sat  = (quot_q > 16'h7FFF) ? 16'h7FFF : quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= tfn_pkg::ScaleReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (cmd_i.op == tfn_pkg::OP_LOAD && cmd_i.step == tfn_pkg::LoadLast) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.op == tfn_pkg::OP_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                        out_valid_q <= 1'b0;
    end
  end

  // vertex store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tfn_pkg::OP_LOAD && cmd_i.step != '0) begin
      unique case (ld_wsel)
        2'd0:    mem_x[waddr] <= ld_val;
        2'd1:    mem_y[waddr] <= ld_val;
        default: mem_z[waddr] <= ld_val;
      endcase
    end
    rd_x_q <= mem_x[raddr];
    rd_y_q <= mem_y[raddr];
    rd_z_q <= mem_z[raddr];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      tfn_pkg::OP_CAPTURE: begin
        in_q  <= in_item_i;
        err_q <= 1'b0;
        for (int k = 0; k < 3; k++) n_q[k] <= '0;
      end
      tfn_pkg::OP_LOAD: begin
        ld_neg_q <= ld_coord[31];
      end
      tfn_pkg::OP_CHECK: begin
        err_q <= idx_err;
      end
      tfn_pkg::OP_READ: begin
        if (cmd_i.step != '0) begin
          v_q[ld_wsel][0] <= rd_x_q;
          v_q[ld_wsel][1] <= rd_y_q;
          v_q[ld_wsel][2] <= rd_z_q;
        end
      end
      tfn_pkg::OP_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e0_q[k] <= {v_q[1][k][31], v_q[1][k]} - {v_q[0][k][31], v_q[0][k]};
          e1_q[k] <= {v_q[2][k][31], v_q[2][k]} - {v_q[0][k][31], v_q[0][k]};
        end
      end
      tfn_pkg::OP_CROSS: begin
        // odd steps open a component, even steps subtract the second term
        if (cmd_i.step != '0) begin
          if (step_m1[0]) w_q[step_m1[2:1]] <= w_q[step_m1[2:1]] - prod_q[66:0];
          else            w_q[step_m1[2:1]] <= prod_q[66:0];
        end
      end
      tfn_pkg::OP_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= w_q[k][66];
          mag_q[k] <= w_q[k][66] ? (67'd0 - w_q[k]) : w_q[k];
        end
      end
      tfn_pkg::OP_NORM: begin
        // bring the largest magnitude to exactly 31 bits
        for (int k = 0; k < 3; k++) begin
          priority if (or_all[66:39] != '0) mag_q[k] <= mag_q[k] >> 8;
          else if (or_all[66:31] != '0)     mag_q[k] <= mag_q[k] >> 1;
          else if (or_all[30:22] == '0)     mag_q[k] <= mag_q[k] << 8;
          else if (!or_all[30])             mag_q[k] <= mag_q[k] << 1;
        end
      end
      tfn_pkg::OP_SQUARE: begin
        if (cmd_i.step == '0) begin
          root_q <= '0;
          bit_q  <= 64'h4000_0000_0000_0000;
        end else if (cmd_i.step == 6'd1) begin
          sum_q <= prod_q[63:0];
        end else begin
          sum_q <= sum_q + prod_q[63:0];
        end
      end
      tfn_pkg::OP_SQRT: begin
        if (sum_q >= sq_trial) begin
          sum_q  <= sum_q - sq_trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      tfn_pkg::OP_DIV: begin
        if (cmd_i.step == '0) begin
          rem_q  <= {1'b0, div_num[46:16]};
          low_q  <= div_num[15:0];
          quot_q <= '0;
        end else if (cmd_i.step == tfn_pkg::DivLast) begin
          n_q[cmd_i.comp] <= neg_q[cmd_i.comp] ? (16'd0 - div_sat) : div_sat;
        end else begin
          if (div_rem2 >= div_dsr) begin
            rem_q  <= 32'(div_rem2 - div_dsr);
            quot_q <= {quot_q[14:0], 1'b1};
          end else begin
            rem_q  <= div_rem2[31:0];
            quot_q <= {quot_q[14:0], 1'b0};
          end
          low_q <= {low_q[14:0], 1'b0};
        end
      end
      tfn_pkg::OP_OUT: begin
        if (out_free) begin
          out_item_q.normal_x    <= n_q[0];
          out_item_q.normal_y    <= n_q[1];
          out_item_q.normal_z    <= n_q[2];
          out_item_q.index_error <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: src/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Loads scaled vertices into a store and returns unit face normals (Q1.15)
// of triangles named by three vertex indices.
// ----------------------------------------------------------------------------
//  port group   direction  handshake                payload
//  in           input      in_valid_i / in_ready_o  in_item_i  (in_item_t)
//  out          output     out_valid_o / out_ready_i out_item_o (out_item_t)
//  cfg          input      cfg_we_i                 cfg_wdata_i (vertex scale)
//
//  A vertex item runs through the load phase; a dropped one (store full) does not.
//  A triangle item is dominated by 32 square root steps and three 18-step
//  divides on one shared unit; a bad index skips them and goes straight to output.
//  One item is in work at a time; the output register lets the next item
//  enter while a result waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal #(
  parameter int unsigned MAX_VERTICES = tfn_pkg::MaxVertices
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [31:0]         cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  tfn_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tfn_pkg::out_item_t  out_item_o
);

  tfn_pkg::cmd_t    cmd;
  tfn_pkg::status_t status;

  tfn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tfn_dp #(
    .MaxVertices (MAX_VERTICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: src/tfn_checker.sv
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks of the triangle face normal block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfn_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input tfn_pkg::out_item_t  out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // a bad index always comes with a zero normal
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.index_error |->
      out_item_o.normal_x == '0 && out_item_o.normal_y == '0 &&
      out_item_o.normal_z == '0)
    else $error("index error with nonzero normal");

  // components saturate at +/-32767
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.normal_x != 16'sh8000 &&
      out_item_o.normal_y != 16'sh8000 && out_item_o.normal_z != 16'sh8000)
    else $error("normal component at most negative code");

  // a result never appears right after an item was taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result too soon after item");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

FILE: verif/triangle_face_normal_test.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_test
// Self-checking bench for the triangle face normal block. Vertex and triangle
// items go in through the input handshake. A scoreboard keeps its own vertex
// store, count and scale and predicts each normal from the exact cross
// product. Results are compared field by field in arrival order. Both sides
// stall at random, and one long output hold-off forces the input to back up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_face_normal_test;

  localparam logic FuncVertex   = 1'b0;
  localparam logic FuncTriangle = 1'b1;
  localparam int   HoldCycles   = 800;

  class normal_scoreboard;
    logic signed [31:0] vx[tfn_pkg::MaxVertices];
    logic signed [31:0] vy[tfn_pkg::MaxVertices];
    logic signed [31:0] vz[tfn_pkg::MaxVertices];
    int unsigned        count;
    logic [31:0]        scale;
    tfn_pkg::out_item_t expected_normals[$];
    int                 errors;

    function new();
      count  = 0;
      scale  = tfn_pkg::ScaleReset;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic logic signed [31:0] scale_coord(logic signed [31:0] c);
      longint      cl;
      logic [95:0] q;
      cl = longint'(c);
      q  = (96'(cl < 0 ? -cl : cl) * 96'(scale) + 96'h8000) >> 16;
      if (cl < 0) begin
        if (q > 96'h8000_0000) q = 96'h8000_0000;
        return -32'(q);
      end
      if (q > 96'h7FFF_FFFF) q = 96'h7FFF_FFFF;
      return 32'(q);
    endfunction

    function automatic logic signed [127:0] wmul(longint a, longint b);
      logic signed [127:0] x, y;
      x = a;
      y = b;
      return x * y;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r, step_w;
      r      = 0;
      step_w = 64'h4000_0000_0000_0000;
      while (step_w > v) step_w >>= 2;
      while (step_w != 0) begin
        if (v >= r + step_w) begin
          v = v - (r + step_w);
          r = (r >> 1) + step_w;
        end else begin
          r >>= 1;
        end
        step_w >>= 2;
      end
      return r;
    endfunction

    function automatic tfn_pkg::out_item_t face_normal(int unsigned a, int unsigned b,
                                                       int unsigned c);
      longint              e0[3], e1[3];
      logic signed [127:0] w[3];
      logic [127:0]        m[3];
      logic [63:0]         s[3];
      logic [63:0]         sum, d, q;
      logic signed [15:0]  n[3];
      int                  maxlen;
      tfn_pkg::out_item_t  r;
      e0[0] = longint'(vx[b]) - longint'(vx[a]);
      e0[1] = longint'(vy[b]) - longint'(vy[a]);
      e0[2] = longint'(vz[b]) - longint'(vz[a]);
      e1[0] = longint'(vx[c]) - longint'(vx[a]);
      e1[1] = longint'(vy[c]) - longint'(vy[a]);
      e1[2] = longint'(vz[c]) - longint'(vz[a]);
      w[0] = wmul(e0[1], e1[2]) - wmul(e0[2], e1[1]);
      w[1] = wmul(e0[2], e1[0]) - wmul(e0[0], e1[2]);
      w[2] = wmul(e0[0], e1[1]) - wmul(e0[1], e1[0]);
      maxlen = 0;
      sum    = 0;
      for (int i = 0; i < 3; i++) begin
        n[i] = 0;
        m[i] = w[i][127] ? -w[i] : w[i];
        for (int j = 127; j >= 0; j--) begin
          if (m[i][j]) begin
            if (j + 1 > maxlen) maxlen = j + 1;
            break;
          end
        end
      end
      if (maxlen != 0) begin
        // align so the largest magnitude has exactly 31 bits
        for (int i = 0; i < 3; i++) begin
          s[i] = (maxlen > 31) ? 64'(m[i] >> (maxlen - 31)) : 64'(m[i] << (31 - maxlen));
          sum += s[i] * s[i];
        end
        d = floor_sqrt(sum);
        if (d != 0) begin
          for (int i = 0; i < 3; i++) begin
            q = ((s[i] << 15) + d / 2) / d;
            if (q > 32767) q = 32767;
            n[i] = w[i][127] ? -16'(q) : 16'(q);
          end
        end
      end
      r.normal_x    = n[0];
      r.normal_y    = n[1];
      r.normal_z    = n[2];
      r.index_error = 1'b0;
      return r;
    endfunction

    function void note_input(tfn_pkg::in_item_t it);
      tfn_pkg::out_item_t r;
      if (it.func == FuncVertex) begin
        if (count < tfn_pkg::MaxVertices) begin
          vx[count] = scale_coord(it.coord_x);
          vy[count] = scale_coord(it.coord_y);
          vz[count] = scale_coord(it.coord_z);
          count++;
        end
        return;
      end
      if (it.corner_a >= count || it.corner_b >= count || it.corner_c >= count) begin
        r = '0;
        r.index_error = 1'b1;
      end else begin
        r = face_normal(32'(it.corner_a), 32'(it.corner_b), 32'(it.corner_c));
      end
      expected_normals.push_back(r);
    endfunction

    task check_result(tfn_pkg::out_item_t got);
      tfn_pkg::out_item_t want;
      if (expected_normals.size() == 0) begin
        report("unexpected result", 32'(got.normal_x), 32'd0);
        return;
      end
      want = expected_normals.pop_front();
      if (got.normal_x !== want.normal_x)
        report("normal_x", 32'(got.normal_x), 32'(want.normal_x));
      if (got.normal_y !== want.normal_y)
        report("normal_y", 32'(got.normal_y), 32'(want.normal_y));
      if (got.normal_z !== want.normal_z)
        report("normal_z", 32'(got.normal_z), 32'(want.normal_z));
      if (got.index_error !== want.index_error)
        report("index_error", 32'(got.index_error), 32'(want.index_error));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  tfn_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  tfn_pkg::out_item_t out_item;

  logic        no_idle;
  logic        hold_req;
  normal_scoreboard board;

  triangle_face_normal DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("triangle_face_normal test failed");
    $finish;
  end

  // output side: random stalls plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) board.check_result(out_item);
      @(negedge clk_i);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready = no_idle || ($urandom_range(99) >= 13);
    end
  end

  task send_item(tfn_pkg::in_item_t it);
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk_i); while (!in_ready);
    board.note_input(it);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task wait_drained();
    while (board.expected_normals.size() != 0) @(posedge clk_i);
    // a vertex item may still be in work
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task write_scale(logic [31:0] value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    board.scale = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'sd65536 * ($urandom_range(200) - 100);
      2: return $urandom_range(2000) - 1000;
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  function automatic tfn_pkg::in_item_t vertex(logic signed [31:0] x,
                                               logic signed [31:0] y,
                                               logic signed [31:0] z);
    tfn_pkg::in_item_t it;
    it          = '0;
    it.func     = FuncVertex;
    it.coord_x  = x;
    it.coord_y  = y;
    it.coord_z  = z;
    it.corner_a = 16'($urandom);
    it.corner_b = 16'($urandom);
    it.corner_c = 16'($urandom);
    return it;
  endfunction

  function automatic tfn_pkg::in_item_t triangle(int unsigned a, int unsigned b,
                                                 int unsigned c);
    tfn_pkg::in_item_t it;
    it          = '0;
    it.func     = FuncTriangle;
    it.coord_x  = $urandom;
    it.coord_y  = $urandom;
    it.coord_z  = $urandom;
    it.corner_a = 16'(a);
    it.corner_b = 16'(b);
    it.corner_c = 16'(c);
    return it;
  endfunction

  function automatic tfn_pkg::in_item_t random_item(int vertex_pct);
    int unsigned n, a, b, c;
    int unsigned roll;
    n = board.count;
    if ($urandom_range(99) < vertex_pct)
      return vertex(pick_coord(), pick_coord(), pick_coord());
    if (n == 0) return triangle($urandom, $urandom, $urandom);
    a    = $urandom_range(n - 1);
    b    = $urandom_range(n - 1);
    c    = $urandom_range(n - 1);
    roll = $urandom_range(99);
    if (roll < 8) begin
      // push one corner out of range
      case ($urandom_range(2))
        0: a = $urandom_range(65535, n);
        1: b = $urandom_range(65535, n);
        default: c = $urandom_range(65535, n);
      endcase
    end else if (roll < 13) begin
      b = a;
    end
    return triangle(a, b, c);
  endfunction

  initial begin
    logic [31:0] scales[6];
    int          errs;
    board     = new();
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty store, extremes, degenerate, bad index
    send_item(triangle(0, 0, 0));
    send_item(vertex(0, 0, 0));
    send_item(vertex(32'sh7FFF_FFFF, 0, 0));
    send_item(vertex(0, 32'sh7FFF_FFFF, 0));
    send_item(vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_item(vertex(1, 2, 3));
    send_item(vertex(-1, 0, 0));
    send_item(triangle(0, 1, 2));
    send_item(triangle(1, 2, 3));
    send_item(triangle(3, 2, 1));
    send_item(triangle(0, 0, 0));
    send_item(triangle(0, 1, 1));
    send_item(triangle(0, 1, 65535));
    send_item(triangle(board.count, 0, 1));
    send_item(triangle(4, 5, 0));
    send_item(triangle(0, 4, 5));
    write_scale(32'hFFFF_FFFF);
    send_item(vertex(32'sh7FFF_FFFF, -32'sd65536, 32'sd1));
    send_item(vertex(32'sh8000_0000, 32'sd65536, -32'sd1));
    send_item(vertex(32'sd3, 32'sd0, 32'sh0000_8000));
    send_item(triangle(6, 7, 8));
    send_item(triangle(8, 7, 6));

    scales = '{32'd0, 32'd1, 32'h0000_8000, $urandom, 32'hFFFF_FFFF, tfn_pkg::ScaleReset};
    foreach (scales[p]) begin
      write_scale(scales[p]);
      no_idle = (p == 3);
      if (p == 1) hold_req = 1'b1;
      for (int k = 0; k < 320; k++) begin
        if (p == 2 && k == 160) wait_drained();
        send_item(random_item(p == 5 ? 75 : 45));
      end
    end
    no_idle = 1'b0;

    while (board.expected_normals.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    errs = board.errors + board.expected_normals.size();
    if (errs == 0) $display("triangle_face_normal test passed");
    else $display("triangle_face_normal test failed");
    $finish;
  end

endmodule
